/* design/rdcm_pkg.sv */
// shared constants, widths and word types of the radial distortion coordinate map
package rdcm_pkg;

  localparam int COORD_BITS    = 12;
  localparam int OUT_FRAC_BITS = 4;
  localparam int DEN_BASE      = 1000;
  localparam int DEN_FRAC      = 16;
  localparam int RAD_FRAC      = 8;
  localparam int OUT_W         = 20;
  localparam int COEF_W        = 32;
  localparam int SCALE_W       = 16;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam int SH1 = 8;
  localparam int SH2 = 24;
  localparam int SH3 = 48;

  localparam int OFF_W    = COORD_BITS + 1;
  localparam int SQ_W     = 2 * COORD_BITS + 1;
  localparam int RAD_IN_W = SQ_W + 2 * RAD_FRAC;
  localparam int ROOT_W   = (RAD_IN_W + 1) / 2;
  localparam int RSQ_W    = 2 * ROOT_W;
  localparam int CUBE_W   = 3 * ROOT_W;
  localparam int T1P_W    = COEF_W + ROOT_W;
  localparam int T1_W     = T1P_W - SH1;
  localparam int T2F_W    = COEF_W + RSQ_W;
  localparam int T2_W     = T2F_W - SH2;
  localparam int P3L_W    = 64;
  localparam int P3H_W    = COEF_W + CUBE_W - 32;
  localparam int T3F_W    = COEF_W + CUBE_W;
  localparam int T3_W     = T3F_W - SH3;
  localparam int DEN_W    = T2_W + 3;
  localparam int D_W      = DEN_W - 1;
  localparam int NUM_SH   = OUT_FRAC_BITS + DEN_FRAC;
  localparam int NUM_W    = COORD_BITS + SCALE_W + NUM_SH;
  localparam int N_W      = DEN_W;
  localparam int Q_W      = OUT_W + 1;
  localparam int CMP_W    = N_W + Q_W;
  localparam int BASE_W   = COORD_BITS + OUT_FRAC_BITS;
  localparam int SUM_W    = Q_W + 2;
  localparam int DIV_LAT  = Q_W + 2;

  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  localparam logic [CFG_AW-1:0] CFG_CENTER_X  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_CENTER_Y  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SCALE_NUM = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_COEF_LIN  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_COEF_SQ   = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_COEF_CUBE = 3'd5;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1000;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] mapped_x;
    logic signed [OUT_W-1:0] mapped_y;
    logic                    range_fault;
  } out_word_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] xu;
    logic signed [OFF_W-1:0] yu;
  } off_t;

  typedef struct packed {
    logic [N_W-1:0]        n;
    logic [D_W-1:0]        d;
    logic                  den_pos;
    logic                  off_neg;
    logic                  off_zero;
    logic [COORD_BITS-1:0] ctr;
  } div_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] val;
    logic                    fault;
  } div_out_t;

endpackage

/* design/radial_distortion_coordinate_map_core.sv */
// radial lens distortion coordinate map, top level
//
// in_word carries one undistorted pixel coordinate, out_word the distorted
// coordinate with 4 fraction bits per axis and a range fault flag. both
// channels move a word when valid is high and stall is low.
// configuration goes through cfg_we / cfg_addr / cfg_wdata, one register per
// write; the user must write only while no word is in flight (the block itself
// does not enforce this); unknown addresses are ignored. a word is accepted
// every cycle while in_stall is low and passes 2 offset/square stages, 21 square
// root stages (one root bit each), 7 multiply and denominator stages, 23 divider
// stages (one quotient bit each plus range check and mapping) and the output register.
// a two-entry output buffer (output register plus skid) keeps the input open
// while one finished word waits; in_stall rises only when both entries hold
// words, and then the whole pipeline holds.
// reset clears all valid bits and loads the register reset values
// (centers 0, scale 1000, coefficients 0).
module radial_distortion_coordinate_map_core import rdcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int TAG_N = ROOT_W + 6;
  localparam int NSTG  = ROOT_W + 9 + DIV_LAT;

  logic [COORD_BITS-1:0] center_x_r;
  logic [COORD_BITS-1:0] center_y_r;
  logic [SCALE_W-1:0]    scale_num_r;
  logic [COEF_W-1:0]     coef_lin_r;
  logic [COEF_W-1:0]     coef_sq_r;
  logic [COEF_W-1:0]     coef_cube_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r  <= '0;
      center_y_r  <= '0;
      scale_num_r <= SCALE_RESET;
      coef_lin_r  <= '0;
      coef_sq_r   <= '0;
      coef_cube_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CENTER_X:  center_x_r  <= cfg_wdata[COORD_BITS-1:0];
        CFG_CENTER_Y:  center_y_r  <= cfg_wdata[COORD_BITS-1:0];
        CFG_SCALE_NUM: scale_num_r <= cfg_wdata[SCALE_W-1:0];
        CFG_COEF_LIN:  coef_lin_r  <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_SQ:   coef_sq_r   <= cfg_wdata[COEF_W-1:0];
        CFG_COEF_CUBE: coef_cube_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [COEF_W-1:0] kl_mag;
  logic [COEF_W-1:0] kq_mag;
  logic [COEF_W-1:0] kc_mag;

  assign kl_mag = coef_lin_r[COEF_W-1]  ? (~coef_lin_r + 1'b1)  : coef_lin_r;
  assign kq_mag = coef_sq_r[COEF_W-1]   ? (~coef_sq_r + 1'b1)   : coef_sq_r;
  assign kc_mag = coef_cube_r[COEF_W-1] ? (~coef_cube_r + 1'b1) : coef_cube_r;

  // flow control
  logic en;
  logic skid_valid_r;
  logic out_valid_r;
  logic [NSTG-1:0] vld_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // offset and squared radius
  off_t           off_s0_r;
  off_t           off_s1_r;
  logic [SQ_W-1:0] sq_s1_r;
  logic signed [2*OFF_W-1:0] sqx;
  logic signed [2*OFF_W-1:0] sqy;
  logic signed [2*OFF_W-1:0] sqsum;

  assign sqx   = off_s0_r.xu * off_s0_r.xu;
  assign sqy   = off_s0_r.yu * off_s0_r.yu;
  assign sqsum = sqx + sqy;

  always_ff @(posedge clk) begin
    if (en) begin
      off_s0_r.xu <= $signed({1'b0, in_word.pixel_x}) - $signed({1'b0, center_x_r});
      off_s0_r.yu <= $signed({1'b0, in_word.pixel_y}) - $signed({1'b0, center_y_r});
      off_s1_r    <= off_s0_r;
      sq_s1_r     <= sqsum[SQ_W-1:0];
    end
  end

  logic [ROOT_W-1:0] root;

  rdcm_sqrt_pipe u_sqrt (
    .clk  (clk),
    .en   (en),
    .sq   (sq_s1_r),
    .root (root)
  );

  off_t off_r [TAG_N];

  always_ff @(posedge clk) begin
    if (en) begin
      off_r[0] <= off_s1_r;
      for (int k = 1; k < TAG_N; k++) begin
        off_r[k] <= off_r[k-1];
      end
    end
  end

  // radius powers and denominator terms
  logic [ROOT_W-1:0] root_m1_r;
  logic [RSQ_W-1:0]  rsq_m1_r;
  logic [T1P_W-1:0]  t1p_m1_r;
  logic [RSQ_W-1:0]  cube_lo_m2_r;
  logic [RSQ_W-1:0]  cube_hi_m2_r;
  logic [T1P_W-1:0]  p2lo_m2_r;
  logic [T1P_W-1:0]  p2hi_m2_r;
  logic [T1_W-1:0]   t1_m2_r;
  logic [CUBE_W-1:0] cube_m3_r;
  logic [T2_W-1:0]   t2_m3_r;
  logic [T1_W-1:0]   t1_m3_r;
  logic [P3L_W-1:0]  p3lo_m4_r;
  logic [P3H_W-1:0]  p3hi_m4_r;
  logic [T1_W-1:0]   t1_m4_r;
  logic [T2_W-1:0]   t2_m4_r;
  logic [T1_W-1:0]   t1_m5_r;
  logic [T2_W-1:0]   t2_m5_r;
  logic [T3_W-1:0]   t3_m5_r;
  logic signed [DEN_W-1:0] den_m6_r;

  logic [CUBE_W-1:0] cube_nxt;
  logic [T2F_W-1:0]  t2f;
  logic [T3F_W-1:0]  t3f;

  assign cube_nxt = (CUBE_W'(cube_hi_m2_r) << ROOT_W) + CUBE_W'(cube_lo_m2_r);
  assign t2f      = (T2F_W'(p2hi_m2_r) << ROOT_W) + T2F_W'(p2lo_m2_r);
  assign t3f      = (T3F_W'(p3hi_m4_r) << 32) + T3F_W'(p3lo_m4_r);

  localparam logic signed [DEN_W-1:0] DEN_BASE_Q = DEN_W'(DEN_BASE) << DEN_FRAC;

  logic signed [DEN_W-1:0] st1;
  logic signed [DEN_W-1:0] st2;
  logic signed [DEN_W-1:0] st3;

  assign st1 = coef_lin_r[COEF_W-1]  ? -$signed(DEN_W'(t1_m5_r)) : $signed(DEN_W'(t1_m5_r));
  assign st2 = coef_sq_r[COEF_W-1]   ? -$signed(DEN_W'(t2_m5_r)) : $signed(DEN_W'(t2_m5_r));
  assign st3 = coef_cube_r[COEF_W-1] ? -$signed(DEN_W'(t3_m5_r)) : $signed(DEN_W'(t3_m5_r));

  always_ff @(posedge clk) begin
    if (en) begin
      root_m1_r    <= root;
      rsq_m1_r     <= RSQ_W'(root) * RSQ_W'(root);
      t1p_m1_r     <= T1P_W'(kl_mag) * T1P_W'(root);
      cube_lo_m2_r <= RSQ_W'(rsq_m1_r[ROOT_W-1:0]) * RSQ_W'(root_m1_r);
      cube_hi_m2_r <= RSQ_W'(rsq_m1_r[RSQ_W-1:ROOT_W]) * RSQ_W'(root_m1_r);
      p2lo_m2_r    <= T1P_W'(kq_mag) * T1P_W'(rsq_m1_r[ROOT_W-1:0]);
      p2hi_m2_r    <= T1P_W'(kq_mag) * T1P_W'(rsq_m1_r[RSQ_W-1:ROOT_W]);
      t1_m2_r      <= t1p_m1_r[T1P_W-1:SH1];
      cube_m3_r    <= cube_nxt;
      t2_m3_r      <= t2f[T2F_W-1:SH2];
      t1_m3_r      <= t1_m2_r;
      p3lo_m4_r    <= P3L_W'(kc_mag) * P3L_W'(cube_m3_r[31:0]);
      p3hi_m4_r    <= P3H_W'(kc_mag) * P3H_W'(cube_m3_r[CUBE_W-1:32]);
      t1_m4_r      <= t1_m3_r;
      t2_m4_r      <= t2_m3_r;
      t1_m5_r      <= t1_m4_r;
      t2_m5_r      <= t2_m4_r;
      t3_m5_r      <= t3f[T3F_W-1:SH3];
      den_m6_r     <= DEN_BASE_Q + st1 + st2 + st3;
    end
  end

  // numerators for both axes
  off_t                  off_m7;
  logic                  den_pos;
  logic [D_W-1:0]        dval;
  logic [COORD_BITS-1:0] magx;
  logic [COORD_BITS-1:0] magy;
  logic signed [OFF_W-1:0] negx;
  logic signed [OFF_W-1:0] negy;
  logic [NUM_W-1:0]      numx;
  logic [NUM_W-1:0]      numy;
  div_in_t               dx_m7_r;
  div_in_t               dy_m7_r;

  assign off_m7  = off_r[TAG_N-1];
  assign den_pos = !den_m6_r[DEN_W-1] && (den_m6_r != '0);
  assign dval    = den_m6_r[D_W-1:0];
  assign negx    = -off_m7.xu;
  assign negy    = -off_m7.yu;
  assign magx    = off_m7.xu[OFF_W-1] ? negx[COORD_BITS-1:0] : off_m7.xu[COORD_BITS-1:0];
  assign magy    = off_m7.yu[OFF_W-1] ? negy[COORD_BITS-1:0] : off_m7.yu[COORD_BITS-1:0];
  assign numx    = (NUM_W'(magx) * NUM_W'(scale_num_r)) << NUM_SH;
  assign numy    = (NUM_W'(magy) * NUM_W'(scale_num_r)) << NUM_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_m7_r.n        <= N_W'(numx) + N_W'(dval >> 1);
      dx_m7_r.d        <= dval;
      dx_m7_r.den_pos  <= den_pos;
      dx_m7_r.off_neg  <= off_m7.xu[OFF_W-1];
      dx_m7_r.off_zero <= (off_m7.xu == '0);
      dx_m7_r.ctr      <= center_x_r;
      dy_m7_r.n        <= N_W'(numy) + N_W'(dval >> 1);
      dy_m7_r.d        <= dval;
      dy_m7_r.den_pos  <= den_pos;
      dy_m7_r.off_neg  <= off_m7.yu[OFF_W-1];
      dy_m7_r.off_zero <= (off_m7.yu == '0);
      dy_m7_r.ctr      <= center_y_r;
    end
  end

  div_out_t dox;
  div_out_t doy;

  rdcm_div_pipe u_div_x (
    .clk  (clk),
    .en   (en),
    .din  (dx_m7_r),
    .dout (dox)
  );

  rdcm_div_pipe u_div_y (
    .clk  (clk),
    .en   (en),
    .din  (dy_m7_r),
    .dout (doy)
  );

  // output register and skid
  out_word_t res_w;
  out_word_t out_word_r;
  out_word_t skid_word_r;
  logic      taken;
  logic      incoming;

  assign res_w.mapped_x    = dox.val;
  assign res_w.mapped_y    = doy.val;
  assign res_w.range_fault = dox.fault | doy.fault;
  assign taken             = out_valid_r && !out_stall;
  assign incoming          = en && vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (taken) begin
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || taken) begin
      out_valid_r <= incoming;
    end else if (incoming) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (taken) begin
        out_word_r <= skid_word_r;
      end
    end else if (!out_valid_r || taken) begin
      out_word_r <= res_w;
    end else begin
      skid_word_r <= res_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* design/rdcm_sqrt_pipe.sv */
// pipelined integer square root, one root bit per stage
module rdcm_sqrt_pipe import rdcm_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   sq,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_IN_W-1:0] rem_r  [ROOT_W-1];
  logic [ROOT_W-1:0]   root_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
    localparam int I = ROOT_W - 1 - k;
    logic [RAD_IN_W-1:0] rem_in;
    logic [RAD_IN_W-1:0] rem_nxt;
    logic [ROOT_W-1:0]   root_in;
    logic [ROOT_W-1:0]   root_nxt;
    logic [RAD_IN_W+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = {sq, {(2 * RAD_FRAC){1'b0}}};
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    always_comb begin
      trial = ((RAD_IN_W + 2)'(root_in) << (I + 1)) + ((RAD_IN_W + 2)'(1) << (2 * I));
      if ({2'b00, rem_in} >= trial) begin
        rem_nxt  = RAD_IN_W'({2'b00, rem_in} - trial);
        root_nxt = root_in | (ROOT_W'(1) << I);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = root_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= root_nxt;
      end
    end

    if (k < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
        end
      end
    end else begin : g_norem
      logic unused_rem;
      assign unused_rem = ^rem_nxt;
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

/* design/rdcm_div_pipe.sv */
// pipelined restoring divider with saturation for one axis
module rdcm_div_pipe import rdcm_pkg::*; (
  input  logic     clk,
  input  logic     en,
  input  div_in_t  din,
  output div_out_t dout
);

  typedef struct packed {
    logic [D_W-1:0]        d;
    logic                  den_pos;
    logic                  off_neg;
    logic                  off_zero;
    logic                  big;
    logic [COORD_BITS-1:0] ctr;
  } side_t;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(OUT_MIN);

  logic [N_W-1:0] rem_b_r;
  side_t          side_b_r;
  logic           big;

  logic [N_W-1:0] rem_r  [Q_W-1];
  logic [Q_W-1:0] q_r    [Q_W];
  side_t          side_r [Q_W];

  div_out_t dout_r;
  div_out_t dout_nxt;

  assign big = CMP_W'(din.n) >= {1'b0, din.d, {Q_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_b_r           <= din.n;
      side_b_r.d        <= din.d;
      side_b_r.den_pos  <= din.den_pos;
      side_b_r.off_neg  <= din.off_neg;
      side_b_r.off_zero <= din.off_zero;
      side_b_r.big      <= big;
      side_b_r.ctr      <= din.ctr;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    localparam int B = Q_W - 1 - k;
    logic [N_W-1:0]   rem_in;
    logic [N_W-1:0]   rem_nxt;
    logic [Q_W-1:0]   q_in;
    logic [Q_W-1:0]   q_nxt;
    side_t            side_in;
    logic [CMP_W-1:0] dsh;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_b_r;
      assign q_in    = '0;
      assign side_in = side_b_r;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin
      dsh = CMP_W'(side_in.d) << B;
      ge  = CMP_W'(rem_in) >= dsh;
      if (ge) begin
        rem_nxt = N_W'(CMP_W'(rem_in) - dsh);
        q_nxt   = q_in | (Q_W'(1) << B);
      end else begin
        rem_nxt = rem_in;
        q_nxt   = q_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]    <= q_nxt;
        side_r[k] <= side_in;
      end
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
        end
      end
    end else begin : g_norem
      logic unused_rem;
      assign unused_rem = ^rem_nxt;
    end
  end

  logic [BASE_W-1:0]       base;
  logic signed [SUM_W-1:0] sum;
  side_t                   sf;

  assign sf   = side_r[Q_W-1];
  assign base = {sf.ctr, {OUT_FRAC_BITS{1'b0}}};
  assign sum  = sf.off_neg ? $signed(SUM_W'(base)) - $signed(SUM_W'(q_r[Q_W-1]))
                           : $signed(SUM_W'(base)) + $signed(SUM_W'(q_r[Q_W-1]));

  always_comb begin
    if (!sf.den_pos) begin
      dout_nxt.fault = 1'b1;
      if (sf.off_zero) begin
        dout_nxt.val = $signed(OUT_W'(base));
      end else if (sf.off_neg) begin
        dout_nxt.val = OUT_W'(OUT_MIN);
      end else begin
        dout_nxt.val = OUT_W'(OUT_MAX);
      end
    end else if (sf.big) begin
      dout_nxt.fault = 1'b1;
      dout_nxt.val   = sf.off_neg ? OUT_W'(OUT_MIN) : OUT_W'(OUT_MAX);
    end else if (sum > SUM_MAX) begin
      dout_nxt.fault = 1'b1;
      dout_nxt.val   = OUT_W'(OUT_MAX);
    end else if (sum < SUM_MIN) begin
      dout_nxt.fault = 1'b1;
      dout_nxt.val   = OUT_W'(OUT_MIN);
    end else begin
      dout_nxt.fault = 1'b0;
      dout_nxt.val   = sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout_r <= dout_nxt;
    end
  end

  assign dout = dout_r;

endmodule

/* design/rdcm_checker.sv */
// port-level checks of the radial distortion coordinate map
module rdcm_port_checks import rdcm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("result word changed while stalled");

  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the output side");

endmodule

bind radial_distortion_coordinate_map_core rdcm_port_checks u_rdcm_port_checks (.*);

/* sim/rdcm_checker.sv */
// checker for the radial distortion coordinate map: predicts each mapped pixel and compares
module rdcm_checker import rdcm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_word_t          in_word,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending,
  output int                mapped_count,
  output int                fault_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] TERM_LIMIT = 128'd1 << 60;

  logic [COORD_BITS-1:0]   ctr_x, ctr_y;
  logic [SCALE_W-1:0]      scale;
  logic signed [COEF_W-1:0] k_lin, k_sq, k_cube;
  out_word_t               mapped_q[$];

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint radius_term(longint coef, logic [127:0] prod, int sh);
    logic [127:0] r;
    r = prod >> sh;
    if (r > TERM_LIMIT) r = TERM_LIMIT;
    return coef < 0 ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  // returns {fault, axis value}
  function automatic logic [OUT_W:0] scale_axis(longint off, longint ctr, longint den);
    longint v, num, q;
    logic   flt;
    flt = 1'b0;
    if (den <= 0) begin
      flt = 1'b1;
      v = off > 0 ? OUT_MAX : (off < 0 ? OUT_MIN : (ctr << OUT_FRAC_BITS));
    end else begin
      num = ((off < 0 ? -off : off) * longint'(scale)) << (OUT_FRAC_BITS + DEN_FRAC);
      q = (num + den / 2) / den;
      v = off < 0 ? (ctr << OUT_FRAC_BITS) - q : (ctr << OUT_FRAC_BITS) + q;
    end
    if (v > OUT_MAX) begin
      v = OUT_MAX;
      flt = 1'b1;
    end else if (v < OUT_MIN) begin
      v = OUT_MIN;
      flt = 1'b1;
    end
    return {flt, v[OUT_W-1:0]};
  endfunction

  function automatic out_word_t map_pixel(in_word_t w);
    longint       xu, yu, den, c1, c2, c3;
    logic [63:0]  sq, r8, r8sq;
    logic [OUT_W:0] ax, ay;
    out_word_t    o;
    xu = longint'(w.pixel_x) - longint'(ctr_x);
    yu = longint'(w.pixel_y) - longint'(ctr_y);
    sq = xu * xu + yu * yu;
    r8 = int_sqrt(sq << 16);
    r8sq = r8 * r8;
    c1 = k_lin;
    c2 = k_sq;
    c3 = k_cube;
    den = (longint'(DEN_BASE) << DEN_FRAC)
        + radius_term(c1, 128'(c1 < 0 ? -c1 : c1) * 128'(r8), SH1)
        + radius_term(c2, 128'(c2 < 0 ? -c2 : c2) * 128'(r8sq), SH2)
        + radius_term(c3, 128'(c3 < 0 ? -c3 : c3) * 128'(r8) * 128'(r8sq), SH3);
    ax = scale_axis(xu, longint'(ctr_x), den);
    ay = scale_axis(yu, longint'(ctr_y), den);
    o.mapped_x = ax[OUT_W-1:0];
    o.mapped_y = ay[OUT_W-1:0];
    o.range_fault = ax[OUT_W] | ay[OUT_W];
    return o;
  endfunction

  assign pending = mapped_q.size();

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      ctr_x <= '0;
      ctr_y <= '0;
      scale <= SCALE_RESET;
      k_lin <= '0;
      k_sq <= '0;
      k_cube <= '0;
      mapped_q.delete();
      fail_count <= 0;
      mapped_count <= 0;
      fault_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CENTER_X:  ctr_x <= cfg_wdata[COORD_BITS-1:0];
          CFG_CENTER_Y:  ctr_y <= cfg_wdata[COORD_BITS-1:0];
          CFG_SCALE_NUM: scale <= cfg_wdata[SCALE_W-1:0];
          CFG_COEF_LIN:  k_lin <= cfg_wdata;
          CFG_COEF_SQ:   k_sq <= cfg_wdata;
          CFG_COEF_CUBE: k_cube <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) mapped_q.push_back(map_pixel(in_word));
      if (out_valid && !out_stall) begin
        mapped_count <= mapped_count + 1;
        if (out_word.range_fault) fault_count <= fault_count + 1;
        if (mapped_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word);
          fail_count <= fail_count + 1;
        end else begin
          want = mapped_q.pop_front();
          if (want.mapped_x !== out_word.mapped_x || want.mapped_y !== out_word.mapped_y
              || want.range_fault !== out_word.range_fault) begin
            $display("%0t: mismatch expected x=%0d y=%0d fault=%0b, got x=%0d y=%0d fault=%0b",
                     $time, want.mapped_x, want.mapped_y, want.range_fault,
                     out_word.mapped_x, out_word.mapped_y, out_word.range_fault);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/tb_radial_distortion_coordinate_map_core.sv */
// testbench top for the radial distortion coordinate map: stimulus, stall patterns and verdict
module tb_radial_distortion_coordinate_map_core import rdcm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 3000;
  localparam int NUM_SETTINGS = 9;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_word;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  int                fail_count, pending, mapped_count, fault_count;
  int                hold_cycles;
  int                stall_mode;
  int                idle_cycles;
  int                pixels_sent;

  radial_distortion_coordinate_map_core DUT (.*);

  rdcm_checker checker_i (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver stall pattern, with a long hold when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_pixel(int px, int py);
    @(negedge clk);
    in_valid <= 1'b1;
    in_word <= '{pixel_x: COORD_BITS'(px), pixel_y: COORD_BITS'(py)};
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  task automatic pause_sender(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_random(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_pixel($urandom, $urandom);
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 6));
    end
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    pause_sender(0);
    while (pending != 0) @(posedge clk);
    repeat (60) @(negedge clk);
  endtask

  logic [CFG_DW-1:0] settings[NUM_SETTINGS][6];

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_CENTER_X;
    cfg_wdata = '0;
    hold_cycles = 0;
    stall_mode = 0;
    pixels_sent = 0;
    // center x, center y, scale, linear, square, cube
    settings[0] = '{2048, 2048, 1000, 0, 0, 0};
    settings[1] = '{4095, 0, 65535, 0, 0, 0};
    settings[2] = '{1000, 3000, 1000, 32'h8000_0000, 0, 0};
    settings[3] = '{2000, 1500, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    settings[4] = '{1024, 768, 1200, 32'hffff_f000, 32'h8000_0000, 32'h8000_0000};
    settings[5] = '{2048, 2048, 1000, 32'h0000_0800, 32'h0000_0100, 32'h0000_4000};
    settings[6] = '{2048, 2048, 900, 32'hffff_ff00, 32'hffff_fff0, 32'hffff_0000};
    for (int i = 7; i < NUM_SETTINGS; i++)
      settings[i] = '{$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535),
                      $urandom >> $urandom_range(8, 31) ^ {32{$urandom_range(0, 1) == 1}},
                      $urandom >> $urandom_range(8, 31) ^ {32{$urandom_range(0, 1) == 1}},
                      $urandom >> $urandom_range(0, 31) ^ {32{$urandom_range(0, 1) == 1}}};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: center at origin
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(4095, 0);
    send_pixel(0, 4095);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    drain();
    write_reg(3'd6, 32'hffff_ffff);
    write_reg(3'd7, 32'h1234_5678);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_reg(CFG_CENTER_X, settings[s][0]);
      write_reg(CFG_CENTER_Y, settings[s][1]);
      write_reg(CFG_SCALE_NUM, settings[s][2]);
      write_reg(CFG_COEF_LIN, settings[s][3]);
      write_reg(CFG_COEF_SQ, settings[s][4]);
      write_reg(CFG_COEF_CUBE, settings[s][5]);
      send_pixel(settings[s][0], settings[s][1]);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(settings[s][0], 0);
      send_pixel(4095, settings[s][1]);
      if (s == 1) hold_cycles = 400;
      send_random(s == 1 ? 120 : 45);
      drain();
    end

    $display("sent %0d pixels over %0d register settings", pixels_sent, NUM_SETTINGS + 1);
    $display("checked %0d mapped words, %0d with range fault", mapped_count, fault_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* sim.f */
design/rdcm_pkg.sv
design/rdcm_sqrt_pipe.sv
design/rdcm_div_pipe.sv
design/radial_distortion_coordinate_map_core.sv
design/rdcm_checker.sv
sim/rdcm_checker.sv
sim/tb_radial_distortion_coordinate_map_core.sv
